// ===== src/decoded_instruction_cache_assert.svh =====
// Assertion macros used by the checker of the decoded instruction cache.
// No dependencies; include by bare file name.
`ifndef DECODED_INSTRUCTION_CACHE_ASSERT_SVH
`define DECODED_INSTRUCTION_CACHE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define DIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define DIC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ===== src/dic_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// decoded instruction cache. No dependencies.
`timescale 1ns / 1ps

package dic_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int MAX_BYTES = 4;
    localparam int NUM_BYTES = 4;
    localparam int ADDR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 3;
    localparam int CYC_W     = 8;
    localparam int HND_W     = 12;
    localparam int CNT_W     = 32;
    localparam int KIND_W    = 2;

    // Payload widths of the two stream channels, rounded up to whole bytes.
    localparam int IN_FIELDS_W  = ADDR_W + NUM_BYTES * BYTE_W + LEN_W + CYC_W + HND_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 6 + LEN_W + CYC_W + HND_W + 2 * CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // One past the highest program address.
    localparam logic [ADDR_W:0] ADDR_LIMIT = 17'h10000;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_FILL   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic load;     // capture the incoming request
        logic execute;  // compare tags, or apply a fill or clear
        logic encode;   // pick the lowest matching entry, start the payload read
        logic deliver;  // load the result register and the counters
    } dic_cmd_t;

    typedef struct packed {
        logic out_free; // result register is empty or being drained
    } dic_status_t;

endpackage

// ===== src/decoded_instruction_cache.sv =====
// Decoded instruction cache: 64-entry fully associative cache with ring
// (first in, first out) replacement, sequenced by a controller over a datapath.
//
// Input stream s_*: one request per handshake; s_tuser carries the kind
// (lookup, fill, clear), s_tdata the address, four bytes, length, cycles and
// handler. Output stream m_*: exactly one result per request; m_tuser is the
// hit flag, m_tdata holds the hit entry fields and both running counters.
// Configuration: cfg_valid/cfg_data writes the enable bit; it is always ready.
// The user is to write it only while no request is in flight; the block
// itself does not enforce this. A request passes through the tag compare
// register, then the priority encoder register and payload RAM read, then
// the result register. A new request is accepted only after the previous
// one has loaded the result register.
// A result waiting on m_tready does not block acceptance of the next request;
// that request then holds in its last step until the result register frees.
// Reset (aresetn low, synchronous): all entries empty, ring pointer and
// counters zero, cache enabled, no result pending.
`timescale 1ns / 1ps

module decoded_instruction_cache
    import dic_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] prog_addr, [23:16] byte_first, [31:24] byte_second,
    // [39:32] byte_third, [47:40] byte_fourth, [50:48] instr_length,
    // [58:51] base_cycles, [70:59] handler_id, [71] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [5:0] hit_index, [8:6] hit_length, [16:9] hit_cycles,
    // [28:17] hit_handler, [60:29] hits_total, [92:61] misses_total, [95:93] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [0] hit
    output logic                  m_tuser
);

    dic_cmd_t    cmd;
    dic_status_t status;

    dic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dic_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== src/dic_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dic_datapath.sv =====
// Datapath of the decoded instruction cache: request register, tag array with
// parallel compare, priority encoder, payload RAM, counters and result register.
// Depends on dic_pkg and dic_ram.
`timescale 1ns / 1ps

module dic_datapath
    import dic_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dic_cmd_t              cmd,
    output dic_status_t           status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    // Request register.
    kind_t              kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [BYTE_W-1:0]  bytes_reg [NUM_BYTES];
    logic [LEN_W-1:0]   len_reg;
    logic [CYC_W-1:0]   cyc_reg;
    logic [HND_W-1:0]   hnd_reg;

    logic               enable_reg;

    // Tag array; a zero length marks an empty entry.
    logic [LEN_W-1:0]   ent_len_reg   [ENTRIES];
    logic [ADDR_W-1:0]  ent_addr_reg  [ENTRIES];
    logic [BYTE_W-1:0]  ent_bytes_reg [ENTRIES][NUM_BYTES];

    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] match_next;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   ring_ptr_reg;
    logic [CNT_W-1:0]   hits_cnt_reg;
    logic [CNT_W-1:0]   miss_cnt_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_hit_reg;

    logic                  enc_hit;
    logic [IDX_W-1:0]      enc_idx;
    logic [MAX_BYTES-1:1]  room;
    logic [LEN_W-1:0]      fill_len;
    logic                  do_fill;
    logic                  do_clear;
    logic                  do_lookup;
    logic [IDX_W-1:0]      ram_raddr;
    logic [CYC_W+HND_W-1:0] ram_rdata;
    logic                  res_hit;
    logic                  res_miss;
    logic [CNT_W-1:0]      hits_cnt_next;
    logic [CNT_W-1:0]      miss_cnt_next;

    assign cfg_ready = 1'b1;

    assign do_lookup = enable_reg && (kind_reg == KIND_LOOKUP);
    assign do_fill   = cmd.execute && enable_reg && (kind_reg == KIND_FILL);
    assign do_clear  = cmd.execute && enable_reg && (kind_reg == KIND_CLEAR);

    always_comb begin
        if (len_reg == '0) begin
            fill_len = LEN_W'(1);
        end else if (len_reg > LEN_W'(MAX_BYTES)) begin
            fill_len = LEN_W'(MAX_BYTES);
        end else begin
            fill_len = len_reg;
        end
    end

    // Byte j of an instruction exists only if prog_addr + j stays in the address space.
    always_comb begin
        for (int j = 1; j < MAX_BYTES; j++) begin
            room[j] = ({1'b0, addr_reg} + (ADDR_W + 1)'(j)) < ADDR_LIMIT;
        end
    end

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            match_next[e] = (ent_len_reg[e] != '0) && (ent_addr_reg[e] == addr_reg)
                            && (ent_bytes_reg[e][0] == bytes_reg[0]);
            for (int j = 1; j < MAX_BYTES; j++) begin
                if (LEN_W'(j) < ent_len_reg[e]) begin
                    match_next[e] = match_next[e] && room[j]
                                    && (ent_bytes_reg[e][j] == bytes_reg[j]);
                end
            end
        end
    end

    // Lowest matching entry wins.
    always_comb begin
        enc_hit = |match_reg;
        enc_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                enc_idx = IDX_W'(i);
            end
        end
    end

    assign ram_raddr = cmd.encode ? enc_idx : hit_idx_reg;

    dic_ram #(
        .WIDTH (CYC_W + HND_W),
        .DEPTH (ENTRIES)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (do_fill),
        .waddr (ring_ptr_reg),
        .wdata ({hnd_reg, cyc_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // hit_reg is only set by a lookup on an enabled cache.
    assign res_hit       = hit_reg;
    assign res_miss      = do_lookup && !hit_reg;
    assign hits_cnt_next = hits_cnt_reg + CNT_W'(res_hit);
    assign miss_cnt_next = miss_cnt_reg + CNT_W'(res_miss);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= kind_t'(s_tuser);
            addr_reg     <= s_tdata[ADDR_W-1:0];
            for (int j = 0; j < NUM_BYTES; j++) begin
                bytes_reg[j] <= s_tdata[ADDR_W + j*BYTE_W +: BYTE_W];
            end
            len_reg      <= s_tdata[ADDR_W + NUM_BYTES*BYTE_W +: LEN_W];
            cyc_reg      <= s_tdata[ADDR_W + NUM_BYTES*BYTE_W + LEN_W +: CYC_W];
            hnd_reg      <= s_tdata[ADDR_W + NUM_BYTES*BYTE_W + LEN_W + CYC_W +: HND_W];
        end
        if (do_fill) begin
            ent_addr_reg[ring_ptr_reg] <= addr_reg;
            for (int j = 0; j < NUM_BYTES; j++) begin
                ent_bytes_reg[ring_ptr_reg][j] <= bytes_reg[j];
            end
        end
        if (cmd.execute) begin
            match_reg <= do_lookup ? match_next : '0;
        end
        if (cmd.encode) begin
            hit_idx_reg <= enc_idx;
        end
        if (cmd.deliver) begin
            out_hit_reg  <= res_hit;
            out_data_reg <= {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                             miss_cnt_next,
                             hits_cnt_next,
                             res_hit ? ram_rdata[CYC_W +: HND_W] : HND_W'(0),
                             res_hit ? ram_rdata[CYC_W-1:0] : CYC_W'(0),
                             res_hit ? ent_len_reg[hit_idx_reg] : LEN_W'(0),
                             res_hit ? 6'(hit_idx_reg) : 6'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b1;
            ring_ptr_reg  <= '0;
            hits_cnt_reg  <= '0;
            miss_cnt_reg  <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < ENTRIES; e++) begin
                ent_len_reg[e] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                enable_reg <= cfg_data;
            end
            if (do_fill) begin
                ent_len_reg[ring_ptr_reg] <= fill_len;
                ring_ptr_reg <= (ring_ptr_reg == IDX_W'(ENTRIES - 1)) ? '0
                                : ring_ptr_reg + IDX_W'(1);
            end
            if (do_clear) begin
                for (int e = 0; e < ENTRIES; e++) begin
                    ent_len_reg[e] <= '0;
                end
                ring_ptr_reg <= '0;
            end
            if (cmd.encode) begin
                hit_reg <= enc_hit;
            end
            if (cmd.deliver) begin
                hits_cnt_reg  <= hits_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_hit_reg;

endmodule

// ===== src/dic_ctrl.sv =====
// Controller state machine of the decoded instruction cache: sequences each
// request through execute, encode and deliver. Depends on dic_pkg.
`timescale 1ns / 1ps

module dic_ctrl
    import dic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  dic_status_t status,
    output dic_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ENCODE,
        ST_DELIVER
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_ENCODE;
            end
            ST_ENCODE: begin
                state_next = ST_DELIVER;
            end
            ST_DELIVER: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready    = ready_reg;
    assign cmd.load    = s_tvalid && ready_reg;
    assign cmd.execute = (state_reg == ST_EXEC);
    assign cmd.encode  = (state_reg == ST_ENCODE);
    assign cmd.deliver = (state_reg == ST_DELIVER) && status.out_free;

endmodule

// ===== src/dic_checker.sv =====
// Port-level checker for the decoded instruction cache, bound to the top level.
// Depends on dic_pkg and decoded_instruction_cache_assert.svh.
`timescale 1ns / 1ps
`include "decoded_instruction_cache_assert.svh"

module dic_checker
    import dic_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    `DIC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `DIC_ASSERT(a_miss_fields_zero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[28:0] == 29'd0, "non-hit result carries entry fields")
    `DIC_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second request taken while one is in flight")
    `DIC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result pending after reset")

endmodule

bind decoded_instruction_cache dic_checker u_dic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
